// ----- src/msie_pkg.sv -----
`default_nettype none

package msie_pkg;

    // Default depth of the data store, in words (a power of two).
    localparam int DATA_WORDS_DEF = 1024;

    localparam logic [31:0] HALT_WORD   = 32'hFFFF_FFFF;
    localparam logic [31:0] PC_TOP_MASK = 32'hF000_0000;
    localparam logic [31:0] PC_STEP     = 32'd4;

    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_RA   = 5'd31;

    // Primary opcodes
    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ORI   = 6'h0D;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2B;

    // Function codes of the register-format opcode
    localparam logic [5:0] FN_SRL = 6'h02;
    localparam logic [5:0] FN_SRA = 6'h03;
    localparam logic [5:0] FN_JR  = 6'h08;
    localparam logic [5:0] FN_ADD = 6'h20;
    localparam logic [5:0] FN_SUB = 6'h22;
    localparam logic [5:0] FN_AND = 6'h24;
    localparam logic [5:0] FN_OR  = 6'h25;
    localparam logic [5:0] FN_NOR = 6'h27;
    localparam logic [5:0] FN_SLT = 6'h2A;

endpackage

`default_nettype wire

// ----- src/mips_subset_instruction_executor.sv -----
// Path: execute register, then output register; a load also passes the write-back
//   register. Throughput: one item per cycle while m_ready takes the output; a
//   load holds the input while the single data store read port returns the word
//   for write-back. Reset: aresetn is synchronous, active low; then the data
//   store is swept to zero, one word a cycle, with s_ready low; the register file
//   reads as zero through per-entry valid bits; prog_len_reg resets to 0.
`default_nettype none

module mips_subset_instruction_executor #(
    parameter int DATA_WORDS = msie_pkg::DATA_WORDS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          cfg_we,
    input  wire logic [30:0]                   cfg_wdata,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [31:0]                   s_instruction_word,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [31:0]                        m_next_pc,
    output logic                               m_halted,
    output logic                               m_illegal_op,
    output logic                               m_reg_written,
    output logic [4:0]                         m_reg_index,
    output logic signed [31:0]                 m_reg_value,
    output logic                               m_mem_written,
    output logic [$clog2(DATA_WORDS)-1:0]      m_mem_index,
    output logic signed [31:0]                 m_mem_value
);

    localparam int IDX_W = $clog2(DATA_WORDS);

    // Control state
    logic              clr_busy_reg;
    logic [IDX_W-1:0]  clr_addr_reg;
    logic [30:0]       prog_len_reg;
    logic [31:0]       pc_reg;
    logic              halt_reg;
    logic              ex_valid_reg;
    logic              wb_valid_reg;
    logic              out_valid_reg;
    logic              fwd_valid_reg;
    logic [31:0]       rf_valid_reg;

    // Execute stage
    logic [31:0]       ex_instr_reg;
    logic [31:0]       rs_data_reg;
    logic [31:0]       rt_data_reg;
    logic              rs_vld_reg;
    logic              rt_vld_reg;

    // Last register file write, for the read issued at the same edge
    logic [4:0]        fwd_idx_reg;
    logic [31:0]       fwd_val_reg;

    // Load write-back stage
    logic              wb_we_reg;
    logic [4:0]        wb_dst_reg;
    logic [31:0]       wb_pc_reg;
    logic              wb_halt_reg;

    // Output register
    logic [31:0]       m_next_pc_reg;
    logic              m_halted_reg;
    logic              m_illegal_op_reg;
    logic              m_reg_written_reg;
    logic [4:0]        m_reg_index_reg;
    logic [31:0]       m_reg_value_reg;
    logic              m_mem_written_reg;
    logic [IDX_W-1:0]  m_mem_index_reg;
    logic [31:0]       m_mem_value_reg;

    // Memories
    logic [31:0]       rf_mem [32];
    logic [31:0]       dmem [DATA_WORDS];
    logic [31:0]       dm_rdata_reg;

    // Execute decode
    logic [31:0]       pc_next;
    logic              halt_next;
    logic              ex_illegal;
    logic              ex_wr;
    logic [4:0]        ex_dst;
    logic [31:0]       ex_res;
    logic              ex_mw;
    logic              ex_is_lw;
    logic [IDX_W-1:0]  ex_midx;
    logic [31:0]       ex_b;

    logic              s_accept;
    logic              out_free;
    logic              ex_to_wb;
    logic              ex_fire;
    logic              wb_fire;
    logic              out_load;
    logic              rf_we;
    logic [4:0]        rf_waddr;
    logic [31:0]       rf_wdata;
    logic              dm_we;

    always_comb begin
        logic [31:0] w;
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [31:0] simm;
        logic [31:0] zimm;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] pc4;
        logic [31:0] maddr;
        logic        dowr;

        w    = ex_instr_reg;
        op   = w[31:26];
        rs   = w[25:21];
        rt   = w[20:16];
        rd   = w[15:11];
        sh   = w[10:6];
        fn   = w[5:0];
        simm = {{16{w[15]}}, w[15:0]};
        zimm = {16'h0000, w[15:0]};
        a = (fwd_valid_reg && fwd_idx_reg == rs) ? fwd_val_reg
          : (rs_vld_reg ? rs_data_reg : 32'h0);
        b = (fwd_valid_reg && fwd_idx_reg == rt) ? fwd_val_reg
          : (rt_vld_reg ? rt_data_reg : 32'h0);
        pc4   = pc_reg + msie_pkg::PC_STEP;
        maddr = a + simm;

        pc_next    = pc_reg;
        halt_next  = halt_reg;
        ex_illegal = 1'b0;
        dowr       = 1'b0;
        ex_dst     = msie_pkg::REG_ZERO;
        ex_res     = 32'h0;
        ex_mw      = 1'b0;
        ex_is_lw   = 1'b0;

        if (!halt_reg) begin
            if (w == msie_pkg::HALT_WORD) begin
                halt_next = 1'b1;
            end else begin
                pc_next = pc4;
                unique case (op)
                    msie_pkg::OP_RTYPE: begin
                        ex_dst = rd;
                        dowr   = 1'b1;
                        unique case (fn)
                            msie_pkg::FN_ADD: ex_res = a + b;
                            msie_pkg::FN_SUB: ex_res = a - b;
                            msie_pkg::FN_AND: ex_res = a & b;
                            msie_pkg::FN_OR:  ex_res = a | b;
                            msie_pkg::FN_SLT: ex_res = {31'h0, $signed(a) < $signed(b)};
                            msie_pkg::FN_NOR: ex_res = ~(a | b);
                            msie_pkg::FN_SRL: ex_res = b >> sh;
                            msie_pkg::FN_SRA: ex_res = 32'($signed(b) >>> sh);
                            msie_pkg::FN_JR: begin
                                dowr    = 1'b0;
                                pc_next = a;
                            end
                            default: begin
                                dowr       = 1'b0;
                                ex_illegal = 1'b1;
                            end
                        endcase
                    end
                    msie_pkg::OP_LW: begin
                        ex_dst   = rt;
                        dowr     = 1'b1;
                        ex_is_lw = 1'b1;
                    end
                    msie_pkg::OP_SW: ex_mw = 1'b1;
                    msie_pkg::OP_BEQ: begin
                        if (a == b) begin
                            pc_next = pc4 + {simm[29:0], 2'b00};
                        end
                    end
                    msie_pkg::OP_ADDI: begin
                        ex_dst = rt;
                        dowr   = 1'b1;
                        ex_res = a + simm;
                    end
                    msie_pkg::OP_ORI: begin
                        ex_dst = rt;
                        dowr   = 1'b1;
                        ex_res = a | zimm;
                    end
                    msie_pkg::OP_J: begin
                        pc_next = (pc4 & msie_pkg::PC_TOP_MASK) | {4'h0, w[25:0], 2'b00};
                    end
                    default: ex_illegal = 1'b1;
                endcase
                if ({1'b0, pc_next[31:2]} >= prog_len_reg) begin
                    halt_next = 1'b1;
                end
            end
        end

        ex_wr   = dowr && ex_dst != msie_pkg::REG_ZERO && ex_dst != msie_pkg::REG_RA;
        // depth is a power of two: the wrap is the low index bits
        ex_midx = maddr[IDX_W-1:0];
        ex_b    = b;
    end

    assign out_free = !out_valid_reg || m_ready;
    assign ex_to_wb = ex_valid_reg && ex_is_lw;
    assign ex_fire  = ex_valid_reg && (ex_is_lw || out_free);
    assign wb_fire  = wb_valid_reg && out_free;
    assign out_load = (ex_fire && !ex_to_wb) || wb_fire;

    // A load in write-back keeps the execute stage empty, so the two never overlap.
    assign s_ready  = !clr_busy_reg &&
                      (wb_valid_reg ? wb_fire : (!ex_valid_reg || (ex_fire && !ex_to_wb)));
    assign s_accept = s_valid && s_ready;

    assign rf_we    = (ex_fire && !ex_to_wb && ex_wr) || (wb_fire && wb_we_reg);
    assign rf_waddr = wb_valid_reg ? wb_dst_reg : ex_dst;
    assign rf_wdata = wb_valid_reg ? dm_rdata_reg : ex_res;
    assign dm_we    = ex_fire && ex_mw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            prog_len_reg  <= '0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            ex_valid_reg  <= 1'b0;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            rf_valid_reg  <= '0;
        end else begin
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == IDX_W'(DATA_WORDS - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (cfg_we) begin
                prog_len_reg <= cfg_wdata;
            end
            if (ex_fire) begin
                pc_reg   <= pc_next;
                halt_reg <= halt_next;
            end
            if (s_accept) begin
                ex_valid_reg <= 1'b1;
            end else if (ex_fire) begin
                ex_valid_reg <= 1'b0;
            end
            if (ex_fire && ex_to_wb) begin
                wb_valid_reg <= 1'b1;
            end else if (wb_fire) begin
                wb_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (rf_we) begin
                fwd_valid_reg          <= 1'b1;
                rf_valid_reg[rf_waddr] <= 1'b1;
            end
        end
    end

    // Register file: two read ports issued at accept, one write port
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ex_instr_reg <= s_instruction_word;
            rs_data_reg  <= rf_mem[s_instruction_word[25:21]];
            rt_data_reg  <= rf_mem[s_instruction_word[20:16]];
            rs_vld_reg   <= rf_valid_reg[s_instruction_word[25:21]];
            rt_vld_reg   <= rf_valid_reg[s_instruction_word[20:16]];
        end
        if (rf_we) begin
            rf_mem[rf_waddr] <= rf_wdata;
            fwd_idx_reg      <= rf_waddr;
            fwd_val_reg      <= rf_wdata;
        end
    end

    // Data store: one write and one read a cycle
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            dmem[clr_addr_reg] <= 32'h0;
        end else if (dm_we) begin
            dmem[ex_midx] <= ex_b;
        end
        if (ex_fire && ex_to_wb) begin
            dm_rdata_reg <= dmem[ex_midx];
        end
    end

    always_ff @(posedge aclk) begin
        if (ex_fire && ex_to_wb) begin
            wb_we_reg   <= ex_wr;
            wb_dst_reg  <= ex_dst;
            wb_pc_reg   <= pc_next;
            wb_halt_reg <= halt_next;
        end
        if (wb_fire) begin
            m_next_pc_reg     <= wb_pc_reg;
            m_halted_reg      <= wb_halt_reg;
            m_illegal_op_reg  <= 1'b0;
            m_reg_written_reg <= wb_we_reg;
            m_reg_index_reg   <= wb_we_reg ? wb_dst_reg : msie_pkg::REG_ZERO;
            m_reg_value_reg   <= wb_we_reg ? dm_rdata_reg : 32'h0;
            m_mem_written_reg <= 1'b0;
            m_mem_index_reg   <= '0;
            m_mem_value_reg   <= 32'h0;
        end else if (ex_fire && !ex_to_wb) begin
            m_next_pc_reg     <= pc_next;
            m_halted_reg      <= halt_next;
            m_illegal_op_reg  <= ex_illegal;
            m_reg_written_reg <= ex_wr;
            m_reg_index_reg   <= ex_wr ? ex_dst : msie_pkg::REG_ZERO;
            m_reg_value_reg   <= ex_wr ? ex_res : 32'h0;
            m_mem_written_reg <= ex_mw;
            m_mem_index_reg   <= ex_mw ? ex_midx : '0;
            m_mem_value_reg   <= ex_mw ? ex_b : 32'h0;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_next_pc     = m_next_pc_reg;
    assign m_halted      = m_halted_reg;
    assign m_illegal_op  = m_illegal_op_reg;
    assign m_reg_written = m_reg_written_reg;
    assign m_reg_index   = m_reg_index_reg;
    assign m_reg_value   = $signed(m_reg_value_reg);
    assign m_mem_written = m_mem_written_reg;
    assign m_mem_index   = m_mem_index_reg;
    assign m_mem_value   = $signed(m_mem_value_reg);

    a_rf_hardwired: assert property (@(posedge aclk) disable iff (!aresetn)
        rf_we |-> (rf_waddr != msie_pkg::REG_ZERO && rf_waddr != msie_pkg::REG_RA))
        else $error("register file write to a hardwired register");

    a_wb_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        wb_valid_reg |-> !ex_valid_reg)
        else $error("execute stage busy while a load writes back");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> (halt_reg && $stable(pc_reg)))
        else $error("halted state changed");

    a_out_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result register overwritten before it was taken");

    a_store_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> (!ex_valid_reg && !wb_valid_reg && !s_ready))
        else $error("item in flight during data store clearing");

endmodule

`default_nettype wire
